[src/sdf_pkg.sv]
// ----------------------------------------------------------------------------
// sdf_pkg: shared types and constants for the signed decimal field formatter
// Payload structs for both channels, the job record passed from the digit
// extractor to the character emitter, and the ASCII codes in use.
// ----------------------------------------------------------------------------
package sdf_pkg;

  localparam int NUM_DIGITS = 10;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // 2^35 / 10 rounded up; exact quotient for any 32-bit dividend after >> 35
  localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  typedef struct packed {
    logic signed [31:0] value;
    logic        [5:0]  field_width;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [NUM_DIGITS-1:0][3:0] digits;  // least significant digit at index 0
    logic [3:0]                 ndig;
    logic                       neg;
    logic [5:0]                 width;
  } job_t;

endpackage

[src/sdf_front.sv]
// ----------------------------------------------------------------------------
// sdf_front: command intake and digit extraction
// Accepts a value and field width, saturates the width, then peels off one
// decimal digit per cycle by reciprocal multiplication and hands the job on.
// ----------------------------------------------------------------------------
module sdf_front #(
  parameter int MAX_FIELD_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  sdf_pkg::in_t  in_data,
  output logic          job_push,
  input  logic          job_full,
  output sdf_pkg::job_t job_data
);
  import sdf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_PUSH = 3'b100
  } state_t;

  localparam logic [6:0] MAX_W = 7'(MAX_FIELD_WIDTH);

  state_t      state_r, state_nxt;
  job_t        job_r, job_nxt;
  logic [31:0] mag_r, mag_nxt;

  logic [63:0] prod;
  logic [31:0] quot;
  logic [3:0]  rem;
  logic [31:0] raw;

  assign raw  = in_data.value;
  assign prod = {32'd0, mag_r} * {32'd0, RECIP_TEN};
  assign quot = {3'd0, prod[63:RECIP_SHIFT]};
  assign rem  = 4'(mag_r - {quot[28:0], 3'd0} - {quot[30:0], 1'b0});

  assign busy     = (state_r != ST_IDLE);
  assign job_data = job_r;
  assign job_push = (state_r == ST_PUSH) && !job_full && (job_r.width != 6'd0);

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    mag_nxt   = mag_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          job_nxt.neg  = raw[31];
          job_nxt.ndig = 4'd0;
          mag_nxt      = raw[31] ? (32'd0 - raw) : raw;
          if ({1'b0, in_data.field_width} > MAX_W) begin
            job_nxt.width = MAX_W[5:0];
          end else begin
            job_nxt.width = in_data.field_width;
          end
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        job_nxt.digits[job_r.ndig] = rem;
        job_nxt.ndig               = job_r.ndig + 4'd1;
        mag_nxt                    = quot;
        if (quot == 32'd0 || job_r.ndig == 4'(NUM_DIGITS - 1)) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        // drop empty fields; otherwise wait for a free queue slot
        if (job_r.width == 6'd0 || !job_full) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    job_r <= job_nxt;
    mag_r <= mag_nxt;
  end

endmodule

[src/sdf_queue.sv]
// ----------------------------------------------------------------------------
// sdf_queue: two-entry job queue
// Decouples digit extraction from character output so each side stalls alone.
// ----------------------------------------------------------------------------
module sdf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sdf_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output sdf_pkg::job_t pop_data
);
  import sdf_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[src/sdf_back.sv]
// ----------------------------------------------------------------------------
// sdf_back: character emitter
// Takes one job from the queue and sends its field one character per cycle:
// sign, digits most significant first, then space fill, last on the final one.
// ----------------------------------------------------------------------------
module sdf_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_empty,
  input  sdf_pkg::job_t job_data,
  output logic          job_pop,
  output logic          out_valid,
  output sdf_pkg::out_t out_data
);
  import sdf_pkg::*;

  job_t       job_r, job_nxt;
  logic       active_r, active_nxt;
  logic [5:0] pos_r, pos_nxt;
  logic       valid_r, valid_nxt;
  out_t       out_r, out_nxt;

  logic [5:0] dpos;
  logic [3:0] didx;
  logic [7:0] ch;

  assign job_pop   = !active_r && !job_empty;
  assign out_valid = valid_r;
  assign out_data  = out_r;

  // position within the digit string, skipping the sign
  assign dpos = pos_r - {5'd0, job_r.neg};
  assign didx = job_r.ndig - 4'd1 - dpos[3:0];

  always_comb begin
    if (job_r.neg && pos_r == 6'd0) begin
      ch = CH_MINUS;
    end else if (dpos < {2'd0, job_r.ndig}) begin
      ch = CH_ZERO + {4'd0, job_r.digits[didx]};
    end else begin
      ch = CH_SPACE;
    end
  end

  always_comb begin
    job_nxt    = job_r;
    active_nxt = active_r;
    pos_nxt    = pos_r;
    valid_nxt  = 1'b0;
    out_nxt    = out_r;
    if (job_pop) begin
      job_nxt    = job_data;
      active_nxt = 1'b1;
      pos_nxt    = 6'd0;
    end else if (active_r) begin
      valid_nxt        = 1'b1;
      out_nxt.out_char = ch;
      out_nxt.last     = (pos_r + 6'd1 == job_r.width);
      pos_nxt          = pos_r + 6'd1;
      if (pos_r + 6'd1 == job_r.width) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      active_r <= active_nxt;
      valid_r  <= valid_nxt;
    end
    job_r <= job_nxt;
    pos_r <= pos_nxt;
    out_r <= out_nxt;
  end

endmodule

[src/signed_decimal_field_format.sv]
// ----------------------------------------------------------------------------
// signed_decimal_field_format: signed integer to left-justified ASCII field
// Formats a signed 32-bit value into a fixed-width decimal text field sent
// one character per transfer.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------
//  input    | start && !busy      | in_data  (value, field_width)
//  result   | out_valid strobe    | out_data (out_char, last)
//
// The front end works through one reciprocal multiply per decimal digit
// (1..10 digits per value) and must finish one command before it takes the next.
// The back end then sends W characters (W = saturated width);
// a two-entry job queue lets extraction of the next value overlap output.
// Reset (rst_n low, synchronous) empties the queue and idles both ends.
// Results cannot be held off; a full queue holds the front end, and busy
// with it, until the back end takes a job. A zero width produces no transfer.
// ----------------------------------------------------------------------------
module signed_decimal_field_format #(
  parameter int MAX_FIELD_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  sdf_pkg::in_t  in_data,
  output logic          out_valid,
  output sdf_pkg::out_t out_data
);
  import sdf_pkg::*;

  logic job_push;
  logic job_full;
  logic job_pop;
  logic job_empty;
  job_t push_job;
  job_t pop_job;

  sdf_front #(
    .MAX_FIELD_WIDTH(MAX_FIELD_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .job_push (job_push),
    .job_full (job_full),
    .job_data (push_job)
  );

  sdf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (push_job),
    .full      (job_full),
    .pop       (job_pop),
    .empty     (job_empty),
    .pop_data  (pop_job)
  );

  sdf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job_data  (pop_job),
    .job_pop   (job_pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[tb/sv/signed_decimal_field_format_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_decimal_field_format_tb: self-checking bench for the field formatter
// Sends signed values with field widths through the start/busy command port
// and predicts each ASCII character of the left-justified field. Every
// character strobe is compared with the oldest predicted one.
// ----------------------------------------------------------------------------
module signed_decimal_field_format_tb;
  import sdf_pkg::*;

  localparam int MAX_WIDTH = 32;
  localparam int NUM_RANDOM = 350;
  localparam int QUIET_ITEMS = 80;
  localparam int TAIL_CYCLES = 80;
  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;

  out_t expected_chars[$];
  int   mismatches = 0;
  bit   gaps_on = 1'b1;

  signed_decimal_field_format u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Build the characters of one field and queue them in output order.
  task automatic format_field(input in_t item);
    logic [31:0] mag;
    logic [3:0]  rev[NUM_DIGITS];
    logic [7:0]  text[NUM_DIGITS + 1];
    int          ndig;
    int          len;
    int          w;
    out_t        ch;
    ndig = 0;
    len = 0;
    mag = item.value[31] ? (32'd0 - item.value) : item.value;
    do begin
      rev[ndig] = 4'(mag % 32'd10);
      ndig++;
      mag = mag / 32'd10;
    end while (mag != 0 && ndig < NUM_DIGITS);
    if (item.value[31]) begin
      text[len] = CH_MINUS;
      len++;
    end
    while (ndig > 0) begin
      ndig--;
      text[len] = CH_ZERO + 8'(rev[ndig]);
      len++;
    end
    w = (item.field_width > MAX_WIDTH) ? MAX_WIDTH : item.field_width;
    for (int k = 0; k < w; k++) begin
      ch.out_char = (k < len) ? text[k] : CH_SPACE;
      ch.last = (k == w - 1);
      expected_chars.push_back(ch);
    end
  endtask

  // Predict on each command transfer first, then check any character strobe.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && start && !busy)
      format_field(in_data);
    if (rst_n && out_valid) begin
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected char: out_char=%h last=%b", out_data.out_char,
                   out_data.last);
      end else begin
        want = expected_chars.pop_front();
        if (out_data.out_char !== want.out_char || out_data.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("char mismatch: expected out_char=%h last=%b, got out_char=%h last=%b",
                     want.out_char, want.last, out_data.out_char, out_data.last);
        end
      end
    end
  end

  // Drop start for a random burst; the data lines carry noise meanwhile.
  task automatic sender_gap();
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 7)) begin
        in_data = {$urandom, 6'($urandom)};
        @(negedge clk);
      end
    end
  endtask

  // Hold one command until the block takes it; returns at a falling edge.
  task automatic send_value(input logic signed [31:0] value, input logic [5:0] width);
    in_data.value = value;
    in_data.field_width = width;
    start = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    sender_gap();
  endtask

  task automatic wait_for_drain();
    while (expected_chars.size() != 0)
      @(negedge clk);
  endtask

  function automatic logic signed [31:0] random_value();
    longint v;
    longint lo;
    longint hi;
    int     d;
    case ($urandom_range(0, 5))
      0: v = longint'($signed($urandom));
      1: begin
        v = 1;
        repeat ($urandom_range(0, 9)) v = v * 10;
        v = v + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1)) v = -v;
      end
      2: begin
        case ($urandom_range(0, 3))
          0: v = INT_MIN;
          1: v = INT_MAX;
          2: v = longint'(INT_MIN) + $urandom_range(0, 3);
          default: v = longint'(INT_MAX) - $urandom_range(0, 3);
        endcase
      end
      default: begin
        d = $urandom_range(1, 10);
        lo = 1;
        repeat (d - 1) lo = lo * 10;
        hi = (d == 10) ? longint'(INT_MAX) : lo * 10 - 1;
        if (d == 1) lo = 0;
        v = $urandom_range(int'(hi), int'(lo));
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v[31:0];
  endfunction

  function automatic logic [5:0] random_width();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(33, 63));
      1, 2: return 6'($urandom_range(1, 12));
      default: return 6'($urandom_range(1, 32));
    endcase
  endfunction

  // Field extremes, sign handling, truncation, zero widths and width saturation.
  task automatic test_directed();
    send_value(0, 6'd1);
    send_value(0, 6'd32);
    send_value(-1, 6'd2);
    send_value(1, 6'd3);
    send_value(9, 6'd1);
    send_value(10, 6'd2);
    send_value(-10, 6'd4);
    send_value(100, 6'd6);
    send_value(INT_MAX, 6'd32);
    send_value(INT_MAX, 6'd10);
    send_value(INT_MIN, 6'd32);
    send_value(INT_MIN, 6'd11);
    send_value(INT_MIN, 6'd5);
    send_value(INT_MIN, 6'd1);
    send_value(1234567890, 6'd10);
    send_value(-999999999, 6'd7);
    send_value(1000000000, 6'd12);
    send_value(42, 6'd0);
    send_value(-42, 6'd0);
    send_value(-7, 6'd33);
    send_value(INT_MIN, 6'd63);
    send_value(INT_MAX, 6'd63);
    send_value(-1, 6'd32);
  endtask

  // Burst of commands, drained; then zero-width commands and one more, drained.
  task automatic test_drain_pause();
    repeat (6) send_value(random_value(), random_width());
    start = 1'b0;
    wait_for_drain();
    repeat (3) send_value(random_value(), 6'd0);
    send_value(random_value(), random_width());
    start = 1'b0;
    wait_for_drain();
  endtask

  task automatic test_random(input int count, input bit with_gaps);
    gaps_on = with_gaps;
    repeat (count) send_value(random_value(), random_width());
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_drain_pause();
    test_random(NUM_RANDOM - QUIET_ITEMS, 1'b1);
    test_random(QUIET_ITEMS, 1'b0);

    start = 1'b0;
    wait_for_drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("signed_decimal_field_format regression: pass");
    end else begin
      $display("signed_decimal_field_format regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("signed_decimal_field_format regression: fail");
    $finish;
  end

endmodule
